FILE: hw/rtl/rbsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_pkg
// Register map and fixed counts for the ray/box slab intersection block.
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int NUM_AXES  = 3;
    localparam int NUM_LANES = 2 * NUM_AXES;
    localparam int NUM_REGS  = 6;
    localparam int REG_IDX_W = 3;
    localparam int NUM_IN_FIELDS = 7;

    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DIR_X    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

endpackage

FILE: hw/rtl/ray_box_slab_intersect_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_top
// Slab test of one configured ray against a stream of axis-aligned boxes.
// ----------------------------------------------------------------------------
// Usage:
//   Write the ray origin and direction over the APB port (registers 0..5 at
//   4-byte steps, 8-byte steps when COORD_WIDTH > 32) while no box is in
//   flight. Boxes enter on s_axis as one word: min x,y,z, max x,y,z, limit.
//   Each box yields one word on m_axis: tdata holds entry and exit distance,
//   tuser holds the hit flag.
//   Throughput: one box per cycle unless m_axis stalls. A box passes the
//   input stage, the six bit-per-stage dividers, three compare stages and
//   the output register. Coordinates are Q16.16 at the default parameters.
//   Reset clears the pipeline valid bits and loads origin 0, direction +x.
//   When the receiver stalls with a word waiting, the whole pipeline holds
//   and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_top
    import rbsi_pkg::*;
#(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // APB
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [((COORD_WIDTH > 32) ? 3 : 2)+REG_IDX_W-1:0] paddr,
    input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] prdata,
    output logic pready,
    // box in
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z, distance_limit (low to high)
    input  logic [((NUM_IN_FIELDS*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // result out
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // entry_distance, exit_distance (low to high)
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // hit
    output logic m_axis_tuser
);

    localparam int W        = COORD_WIDTH;
    localparam int F        = FRACTION_BITS;
    localparam int QW       = W + 1 + F;
    localparam int ADDR_LSB = (W > 32) ? 3 : 2;
    localparam int DATA_W   = (W > 32) ? 64 : 32;
    localparam int OUT_TW   = ((2*W+7)/8)*8;

    localparam logic [W-1:0]  FIX_ONE = {{(W-1){1'b0}}, 1'b1} << F;
    localparam logic [W-1:0]  VMAX    = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  VMIN    = {1'b1, {(W-1){1'b0}}};
    localparam logic [QW-1:0] LIM_POS = {{(F+2){1'b0}}, {(W-1){1'b1}}};
    localparam logic [QW-1:0] LIM_NEG = {{(F+1){1'b0}}, 1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [NUM_LANES-1:0] neg;
        logic [NUM_AXES-1:0]  dz;
        logic [NUM_AXES-1:0]  in_slab;
        logic [NUM_AXES-1:0]  below;
        logic [W-1:0]         limit;
    } t_side;

    // ---------------- configuration ----------------
    logic [W-1:0]           r_cfg [NUM_REGS];
    logic [REG_IDX_W-1:0]   w_idx;
    logic                   w_wr;

    assign w_idx  = paddr[ADDR_LSB +: REG_IDX_W];
    assign w_wr   = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_ORIGIN_X] <= '0;
            r_cfg[REG_ORIGIN_Y] <= '0;
            r_cfg[REG_ORIGIN_Z] <= '0;
            r_cfg[REG_DIR_X]    <= FIX_ONE;
            r_cfg[REG_DIR_Y]    <= '0;
            r_cfg[REG_DIR_Z]    <= '0;
        end else if (w_wr && (w_idx < REG_IDX_W'(NUM_REGS))) begin
            r_cfg[w_idx] <= pwdata[W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_idx < REG_IDX_W'(NUM_REGS)) begin
            prdata = DATA_W'(r_cfg[w_idx]);
        end
    end

    // ---------------- pipeline control ----------------
    logic r_out_vld;
    logic w_en;

    assign w_en          = ~r_out_vld | m_axis_tready;
    assign s_axis_tready = w_en;

    logic [W-1:0] w_den [NUM_AXES];
    for (genvar a = 0; a < NUM_AXES; a++) begin : g_den
        logic [W-1:0] dir;
        assign dir      = r_cfg[REG_DIR_X + REG_IDX_W'(a)];
        assign w_den[a] = dir[W-1] ? (~dir + 1'b1) : dir;
    end

    // ---------------- input stage ----------------
    logic          r_p0_vld;
    t_side         r_p0_side;
    logic [W:0]    r_mag [NUM_LANES];
    t_side         n_p0_side;
    logic [W:0]    n_mag [NUM_LANES];

    always_comb begin
        logic signed [W:0] lo, hi, o, diff;
        logic [W-1:0]      dir;
        n_p0_side = '0;
        n_p0_side.limit = s_axis_tdata[6*W +: W];
        for (int a = 0; a < NUM_AXES; a++) begin
            lo  = {s_axis_tdata[a*W+W-1], s_axis_tdata[a*W +: W]};
            hi  = {s_axis_tdata[(a+3)*W+W-1], s_axis_tdata[(a+3)*W +: W]};
            o   = {r_cfg[a][W-1], r_cfg[a]};
            dir = r_cfg[REG_DIR_X + REG_IDX_W'(a)];
            n_p0_side.dz[a]      = (dir == '0);
            n_p0_side.in_slab[a] = (lo <= o) && (o <= hi);
            n_p0_side.below[a]   = (o < lo);
            diff = lo - o;
            n_mag[a] = diff[W] ? (~diff + 1'b1) : diff;
            n_p0_side.neg[a] = diff[W] ^ dir[W-1];
            diff = hi - o;
            n_mag[a+NUM_AXES] = diff[W] ? (~diff + 1'b1) : diff;
            n_p0_side.neg[a+NUM_AXES] = diff[W] ^ dir[W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_vld <= 1'b0;
        end else if (w_en) begin
            r_p0_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0_side <= n_p0_side;
            for (int j = 0; j < NUM_LANES; j++) begin
                r_mag[j] <= n_mag[j];
            end
        end
    end

    // ---------------- dividers ----------------
    logic [QW-1:0] w_quo [NUM_LANES];
    for (genvar j = 0; j < NUM_LANES; j++) begin : g_div
        rbsi_div #(
            .W (W),
            .F (F)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_mag[j]),
            .i_den (w_den[j % NUM_AXES]),
            .o_quo (w_quo[j])
        );
    end

    logic  r_dl_vld  [QW];
    t_side r_dl_side [QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) begin
                r_dl_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_dl_vld[0] <= r_p0_vld;
            for (int k = 1; k < QW; k++) begin
                r_dl_vld[k] <= r_dl_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl_side[0] <= r_p0_side;
            for (int k = 1; k < QW; k++) begin
                r_dl_side[k] <= r_dl_side[k-1];
            end
        end
    end

    // ---------------- saturate and sign ----------------
    logic         r_s1_vld;
    t_side        r_s1_side;
    logic [W-1:0] r_t [NUM_LANES];
    logic [W-1:0] n_t [NUM_LANES];

    always_comb begin
        logic [QW-1:0] lim, qs;
        for (int j = 0; j < NUM_LANES; j++) begin
            lim    = r_dl_side[QW-1].neg[j] ? LIM_NEG : LIM_POS;
            qs     = (w_quo[j] > lim) ? lim : w_quo[j];
            n_t[j] = r_dl_side[QW-1].neg[j] ? (~qs[W-1:0] + 1'b1) : qs[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= r_dl_vld[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_side <= r_dl_side[QW-1];
            for (int j = 0; j < NUM_LANES; j++) begin
                r_t[j] <= n_t[j];
            end
        end
    end

    // ---------------- near / far per axis ----------------
    logic         r_s2_vld;
    logic         r_s2_miss;
    logic [W-1:0] r_s2_lim;
    logic [W-1:0] r_near [NUM_AXES];
    logic [W-1:0] r_far  [NUM_AXES];
    logic [W-1:0] n_near [NUM_AXES];
    logic [W-1:0] n_far  [NUM_AXES];
    logic         n_s2_miss;

    always_comb begin
        logic signed [W-1:0] t0, t1;
        n_s2_miss = 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
            t0 = r_t[a];
            t1 = r_t[a+NUM_AXES];
            if (r_s1_side.dz[a]) begin
                if (r_s1_side.in_slab[a]) begin
                    n_near[a] = VMIN;
                    n_far[a]  = VMAX;
                end else begin
                    n_s2_miss = 1'b1;
                    n_near[a] = r_s1_side.below[a] ? VMAX : VMIN;
                    n_far[a]  = r_s1_side.below[a] ? VMAX : VMIN;
                end
            end else begin
                n_near[a] = (t0 < t1) ? t0 : t1;
                n_far[a]  = (t0 < t1) ? t1 : t0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_miss <= n_s2_miss;
            r_s2_lim  <= r_s1_side.limit;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_near[a] <= n_near[a];
                r_far[a]  <= n_far[a];
            end
        end
    end

    // ---------------- entry / exit ----------------
    logic         r_s3_vld;
    logic         r_s3_miss;
    logic [W-1:0] r_entry;
    logic [W-1:0] r_exit;
    logic [W-1:0] n_entry;
    logic [W-1:0] n_exit;

    always_comb begin
        n_entry = '0;
        n_exit  = r_s2_lim;
        for (int a = 0; a < NUM_AXES; a++) begin
            if ($signed(r_near[a]) > $signed(n_entry)) begin
                n_entry = r_near[a];
            end
            if ($signed(r_far[a]) < $signed(n_exit)) begin
                n_exit = r_far[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_en) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_miss <= r_s2_miss;
            r_entry   <= n_entry;
            r_exit    <= n_exit;
        end
    end

    // ---------------- output register ----------------
    logic              r_hit;
    logic [OUT_TW-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit      <= ~r_s3_miss & ($signed(r_entry) <= $signed(r_exit));
            r_out_data <= OUT_TW'({r_exit, r_entry});
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_hit;

endmodule

FILE: hw/rtl/rbsi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined restoring divider, one quotient bit per stage.
// Quotient = (num << F) / den, unsigned.
// ----------------------------------------------------------------------------
module rbsi_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [W:0]        i_num,
    input  logic [W-1:0]      i_den,
    output logic [W+F:0]      o_quo
);

    localparam int QW = W + 1 + F;

    logic [W:0]    r_rem [QW];
    logic [W:0]    r_num [QW];
    logic [QW-1:0] r_quo [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [W:0]    p_rem;
        logic [W:0]    p_num;
        logic [QW-1:0] p_quo;
        logic [W:0]    sh;
        logic          ge;
        if (g == 0) begin : g_first
            assign p_rem = '0;
            assign p_num = i_num;
            assign p_quo = '0;
        end else begin : g_next
            assign p_rem = r_rem[g-1];
            assign p_num = r_num[g-1];
            assign p_quo = r_quo[g-1];
        end
        // for nonzero den the remainder stays below den <= 2^(W-1), so its top bit is always zero
        assign sh = {p_rem[W-1:0], p_num[W]};
        assign ge = (sh >= {1'b0, i_den});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= ge ? (sh - {1'b0, i_den}) : sh;
                r_num[g] <= {p_num[W-1:0], 1'b0};
                r_quo[g] <= {p_quo[QW-2:0], ge};
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule
